// ===== design/ssrr_pkg.sv =====
// Shared types, constants and helpers for the sticky-session round-robin dispatcher.
// Used by ssrr_lookup, sticky_session_round_robin and ssrr_checker.
package ssrr_pkg;

	localparam int TABLE_DEPTH  = 256;
	localparam int ADDR_W       = $clog2(TABLE_DEPTH);
	localparam int FILL_W       = ADDR_W + 1;
	localparam int MAX_REPLICAS = 64;
	localparam int MAX_LANES    = 64;
	localparam int KEY_W        = 32;
	localparam int TAG_W        = 32;
	localparam int IDX_W        = 6;
	localparam int TGT_W        = 2 * IDX_W;
	localparam int CFG_W        = 7;
	localparam int STATUS_W     = 2;
	localparam int REP_TOP      = (MAX_REPLICAS < 64) ? MAX_REPLICAS : 64;
	localparam int LANE_TOP     = (MAX_LANES < 64) ? MAX_LANES : 64;

	localparam logic [STATUS_W-1:0] ST_ASSIGNED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNUSED   = 2'd3;

	localparam logic REG_REPLICA_COUNT = 1'b0;
	localparam logic REG_LANES         = 1'b1;

	typedef enum logic [1:0] {
		DSP_IDLE,
		DSP_LOOK,
		DSP_FIN
	} dsp_state_t;

	typedef enum logic {
		LK_IDLE,
		LK_SCAN
	} lk_state_t;

	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] key;
		logic [TGT_W-1:0] target;
	} lk_req_t;

	typedef struct packed {
		logic             done;
		logic             hit;
		logic             full;
		logic [TGT_W-1:0] target;
	} lk_rsp_t;

	function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] top);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > top) begin
			r = top;
		end
		return r;
	endfunction

endpackage

// ===== design/ssrr_lookup.sv =====
// Session table and its scan sequencer: one shared key comparator walks the used entries.
// A miss with room left appends the key and its new target. Depends on ssrr_pkg.
module ssrr_lookup
	import ssrr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  lk_req_t req,
	output lk_rsp_t rsp
);

	lk_state_t state_q, state_d;
	logic [FILL_W-1:0] addr_q;
	logic [FILL_W-1:0] fill_q;
	logic rd_vld_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W+TGT_W-1:0] rd_q;
	logic [KEY_W+TGT_W-1:0] mem [TABLE_DEPTH];

	logic match;
	logic more;
	logic rd_en;
	logic wr_en;
	logic table_full;

	assign match      = rd_vld_q && (rd_q[KEY_W+TGT_W-1:TGT_W] == key_q);
	assign more       = addr_q < fill_q;
	assign table_full = fill_q == FILL_W'(TABLE_DEPTH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			LK_IDLE: begin
				if (req.start) state_d = LK_SCAN;
			end
			LK_SCAN: begin
				if (match || (!more && !rd_vld_q)) state_d = LK_IDLE;
			end
			default: state_d = LK_IDLE;
		endcase
	end

	always_comb begin
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		rsp.done   = 1'b0;
		rsp.hit    = 1'b0;
		rsp.full   = 1'b0;
		rsp.target = req.target;
		case (state_q)
			LK_SCAN: begin
				if (match) begin
					rsp.done   = 1'b1;
					rsp.hit    = 1'b1;
					rsp.target = rd_q[TGT_W-1:0];
				end else if (more) begin
					rd_en = 1'b1;
				end else if (!rd_vld_q) begin
					rsp.done = 1'b1;
					rsp.full = table_full;
					wr_en    = !table_full;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= LK_IDLE;
			addr_q   <= '0;
			fill_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == LK_IDLE) begin
				addr_q   <= '0;
				rd_vld_q <= 1'b0;
			end else begin
				rd_vld_q <= rd_en;
				if (rd_en) addr_q <= addr_q + FILL_W'(1);
			end
			if (wr_en) fill_q <= fill_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && state_q == LK_IDLE) key_q <= req.key;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[addr_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[fill_q[ADDR_W-1:0]] <= {key_q, req.target};
	end

endmodule

// ===== design/sticky_session_round_robin.sv =====
// Top level of the sticky-session round-robin dispatcher: stream ports, configuration
// registers, round-robin counters and the output register. Depends on ssrr_pkg, ssrr_lookup.
// Throughput: one word at a time; the key scan reads one table entry per cycle.
// Reset clears the table fill count, both counters and the output valid; both registers reset to 1.
module sticky_session_round_robin
	import ssrr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,   // session_key[31:0], request_tag[63:32]
	input  logic             s_tuser,   // session_valid[0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [47:0]      m_tdata,   // replica_index[5:0], lane_index[11:6], tag_out[43:12], zero
	output logic [1:0]       m_tuser,   // status[1:0]
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	dsp_state_t state_q, state_d;
	logic [CFG_W-1:0] rep_cnt_q, lane_cnt_q;
	logic [IDX_W-1:0] rep_q, lane_q;
	logic [TAG_W-1:0] tag_q;
	logic [TGT_W-1:0] res_tgt_q;
	logic [STATUS_W-1:0] res_status_q;
	logic m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic [STATUS_W-1:0] m_tuser_q;

	logic [CFG_W-1:0] nrep, nlane;
	logic [IDX_W-1:0] rep_eff, lane_eff;
	logic [CFG_W-1:0] rep_inc, lane_inc;
	logic accept;
	logic out_load;
	logic advance;
	lk_req_t req;
	lk_rsp_t rsp;

	assign nrep     = clamp_count(rep_cnt_q, CFG_W'(REP_TOP));
	assign nlane    = clamp_count(lane_cnt_q, CFG_W'(LANE_TOP));
	assign rep_eff  = ({1'b0, rep_q} >= nrep) ? '0 : rep_q;
	assign lane_eff = ({1'b0, lane_q} >= nlane) ? '0 : lane_q;
	assign rep_inc  = {1'b0, rep_eff} + CFG_W'(1);
	assign lane_inc = {1'b0, lane_eff} + CFG_W'(1);
	assign accept   = s_tvalid && s_tready;
	assign advance  = rsp.done && !rsp.hit && !rsp.full;

	assign req.start  = accept && s_tuser;
	assign req.key    = s_tdata[KEY_W-1:0];
	assign req.target = {rep_eff, lane_eff};

	ssrr_lookup u_lookup (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			DSP_IDLE: begin
				if (s_tvalid) state_d = s_tuser ? DSP_LOOK : DSP_FIN;
			end
			DSP_LOOK: begin
				if (rsp.done) state_d = DSP_FIN;
			end
			DSP_FIN: begin
				if (!m_tvalid_q || m_tready) state_d = DSP_IDLE;
			end
			default: state_d = DSP_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			DSP_IDLE: s_tready = 1'b1;
			DSP_FIN:  out_load = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= DSP_IDLE;
			rep_cnt_q  <= CFG_W'(1);
			lane_cnt_q <= CFG_W'(1);
			rep_q      <= '0;
			lane_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_REPLICA_COUNT) rep_cnt_q <= cfg_wdata;
				if (cfg_index == REG_LANES) lane_cnt_q <= cfg_wdata;
				rep_q  <= '0;
				lane_q <= '0;
			end else if (advance) begin
				if (lane_inc >= nlane) begin
					lane_q <= '0;
					rep_q  <= (rep_inc >= nrep) ? '0 : rep_inc[IDX_W-1:0];
				end else begin
					lane_q <= lane_inc[IDX_W-1:0];
					rep_q  <= rep_eff;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q <= s_tdata[KEY_W+TAG_W-1:KEY_W];
			if (!s_tuser) begin
				res_status_q <= ST_INVALID;
				res_tgt_q    <= '0;
			end
		end
		if (rsp.done) begin
			res_status_q <= rsp.full ? ST_FULL : ST_ASSIGNED;
			res_tgt_q    <= rsp.full ? '0 : rsp.target;
		end
		if (out_load) begin
			m_tdata_q <= {4'b0, tag_q, res_tgt_q[IDX_W-1:0], res_tgt_q[TGT_W-1:IDX_W]};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== design/ssrr_checker.sv =====
// Port-level checker for sticky_session_round_robin, attached by the bind below.
// Depends on ssrr_pkg for the status codes.
module ssrr_checker
	import ssrr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A word is taken only when the block is free, so it cannot take two in a row.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken on consecutive cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != ST_UNUSED))
		else $error("unused status code");

	a_error_target: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ((m_tuser == ST_INVALID) || (m_tuser == ST_FULL)))
		|-> (m_tdata[11:0] == 12'd0))
		else $error("error result carries a target");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output changed");

endmodule

bind sticky_session_round_robin ssrr_checker u_ssrr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
